// ===== src/vmpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmpc_pkg: valve motor position control package
// Shared types, codes and register reset values for the controller.
// ----------------------------------------------------------------------------
package vmpc_pkg;

	// Event codes of an input transaction
	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_PULSE  = 3'd1;
	localparam logic [2:0] OP_SETPOS = 3'd2;
	localparam logic [2:0] OP_AOPEN  = 3'd3;
	localparam logic [2:0] OP_ACLOSE = 3'd4;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_STALL_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_MAX_RT_OPEN   = 2'd1;
	localparam logic [1:0] REG_MAX_RT_CLOSE  = 2'd2;
	localparam logic [1:0] REG_MIN_RANGE     = 2'd3;

	localparam int unsigned PADDR_W = 4;

	localparam logic [7:0]  RST_STALL_TIMEOUT = 8'd20;
	localparam logic [15:0] RST_MAX_RT_OPEN   = 16'd1000;
	localparam logic [15:0] RST_MAX_RT_CLOSE  = 16'd1000;
	localparam logic [14:0] RST_MIN_RANGE     = 15'd100;

	// Drive pin patterns, bit 0 open, bit 1 close
	localparam logic [1:0] PINS_OFF   = 2'b00;
	localparam logic [1:0] PINS_OPEN  = 2'b01;
	localparam logic [1:0] PINS_CLOSE = 2'b10;

	typedef enum logic [1:0] {
		MOVE_OFF   = 2'd0,
		MOVE_OPEN  = 2'd1,
		MOVE_CLOSE = 2'd2
	} dir_t;

	typedef enum logic [1:0] {
		CMD_NONE   = 2'd0,
		CMD_SET    = 2'd1,
		CMD_AOPEN  = 2'd2,
		CMD_ACLOSE = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [7:0]  stall_timeout_ticks;
		logic [15:0] max_runtime_open;
		logic [15:0] max_runtime_close;
		logic [14:0] min_range;
	} cfg_t;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [15:0] target;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] position;
		logic               running;
		logic               drive_open;
		logic               drive_close;
		logic               adapted;
		logic               done_res;
		logic               ok;
	} out_item_t;

	typedef struct packed {
		dir_t               direction;
		logic [1:0]         drive_pins;
		logic [7:0]         stall_count;
		logic [15:0]        run_ticks;
		logic signed [15:0] pos_count;
		logic signed [15:0] pos_max;
		logic signed [15:0] pos_target;
		cmd_t               pending_cmd;
	} ctl_state_t;

endpackage

// ===== src/vmpc_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmpc_regs: configuration registers
// APB-style register file holding the stall timeout, runtime limits and the
// minimum travel range.
// ----------------------------------------------------------------------------
module vmpc_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [vmpc_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output vmpc_pkg::cfg_t                   cfg
);

	logic             wr_en;
	logic [1:0]       reg_idx;
	vmpc_pkg::cfg_t   cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stall_timeout_ticks <= vmpc_pkg::RST_STALL_TIMEOUT;
			cfg_q.max_runtime_open    <= vmpc_pkg::RST_MAX_RT_OPEN;
			cfg_q.max_runtime_close   <= vmpc_pkg::RST_MAX_RT_CLOSE;
			cfg_q.min_range           <= vmpc_pkg::RST_MIN_RANGE;
		end else if (wr_en) begin
			unique case (reg_idx)
				vmpc_pkg::REG_STALL_TIMEOUT: cfg_q.stall_timeout_ticks <= pwdata[7:0];
				vmpc_pkg::REG_MAX_RT_OPEN:   cfg_q.max_runtime_open    <= pwdata[15:0];
				vmpc_pkg::REG_MAX_RT_CLOSE:  cfg_q.max_runtime_close   <= pwdata[15:0];
				vmpc_pkg::REG_MIN_RANGE:     cfg_q.min_range           <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			vmpc_pkg::REG_STALL_TIMEOUT: prdata = {24'd0, cfg_q.stall_timeout_ticks};
			vmpc_pkg::REG_MAX_RT_OPEN:   prdata = {16'd0, cfg_q.max_runtime_open};
			vmpc_pkg::REG_MAX_RT_CLOSE:  prdata = {16'd0, cfg_q.max_runtime_close};
			vmpc_pkg::REG_MIN_RANGE:     prdata = {17'd0, cfg_q.min_range};
			default:                     prdata = 32'd0;
		endcase
	end

endmodule

// ===== src/vmpc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmpc_core: controller next-state logic
// Applies one event to the controller state and forms the status result.
// ----------------------------------------------------------------------------
module vmpc_core (
	input  vmpc_pkg::in_item_t    item,
	input  vmpc_pkg::ctl_state_t  cur,
	input  vmpc_pkg::cfg_t        cfg,
	output vmpc_pkg::ctl_state_t  nxt,
	output vmpc_pkg::out_item_t   res
);

	logic               busy;
	logic               done;
	logic               ok;
	logic signed [15:0] tgt;
	logic signed [15:0] neg_pos;
	logic signed [15:0] min_rng;

	always_comb begin
		nxt     = cur;
		done    = 1'b0;
		ok      = 1'b0;
		busy    = (cur.direction != vmpc_pkg::MOVE_OFF);
		tgt     = item.target;
		neg_pos = 16'sd0;
		min_rng = $signed({1'b0, cfg.min_range});

		unique case (item.op)
			vmpc_pkg::OP_TICK: begin
				if (cur.stall_count != 8'hFF)
					nxt.stall_count = cur.stall_count + 8'd1;
				if (nxt.stall_count > cfg.stall_timeout_ticks) begin
					nxt.drive_pins = vmpc_pkg::PINS_OFF;
					nxt.direction  = vmpc_pkg::MOVE_OFF;
				end
				if (nxt.direction != vmpc_pkg::MOVE_OFF && cur.run_ticks != 16'hFFFF)
					nxt.run_ticks = cur.run_ticks + 16'd1;
				// target stop only once the travel is known
				if (cur.pos_max != 16'sd0) begin
					if (nxt.direction == vmpc_pkg::MOVE_OPEN && cur.pos_count >= cur.pos_target)
						nxt.drive_pins = vmpc_pkg::PINS_OFF;
					else if (nxt.direction == vmpc_pkg::MOVE_CLOSE
						&& cur.pos_count <= cur.pos_target)
						nxt.drive_pins = vmpc_pkg::PINS_OFF;
				end
				if (cur.pending_cmd == vmpc_pkg::CMD_AOPEN
					&& nxt.run_ticks > cfg.max_runtime_open)
					nxt.drive_pins = vmpc_pkg::PINS_OFF;
				if (cur.pending_cmd == vmpc_pkg::CMD_ACLOSE
					&& nxt.run_ticks > cfg.max_runtime_close)
					nxt.drive_pins = vmpc_pkg::PINS_OFF;
				// finish the pending command once the motor is disabled
				if (cur.pending_cmd != vmpc_pkg::CMD_NONE
					&& nxt.direction == vmpc_pkg::MOVE_OFF) begin
					done = 1'b1;
					if (cur.pending_cmd == vmpc_pkg::CMD_AOPEN) begin
						nxt.pos_count = 16'sd0;
						ok = (nxt.run_ticks <= cfg.max_runtime_open);
					end else if (cur.pending_cmd == vmpc_pkg::CMD_ACLOSE) begin
						if (nxt.run_ticks <= cfg.max_runtime_close) begin
							neg_pos = (cur.pos_count == 16'sh8000) ? 16'sh7FFF
								: -cur.pos_count;
							nxt.pos_count = 16'sd0;
							if (neg_pos < min_rng) begin
								nxt.pos_max = 16'sd0;
							end else begin
								nxt.pos_max = neg_pos;
								ok = 1'b1;
							end
						end
					end
					nxt.pending_cmd = vmpc_pkg::CMD_NONE;
				end
			end
			vmpc_pkg::OP_PULSE: begin
				if (cur.direction == vmpc_pkg::MOVE_OPEN && cur.pos_count != 16'sh7FFF)
					nxt.pos_count = cur.pos_count + 16'sd1;
				else if (cur.direction == vmpc_pkg::MOVE_CLOSE
					&& cur.pos_count != 16'sh8000)
					nxt.pos_count = cur.pos_count - 16'sd1;
				nxt.stall_count = 8'd0;
			end
			vmpc_pkg::OP_SETPOS: begin
				if (!busy) begin
					if (tgt < 16'sd0)
						tgt = 16'sd0;
					if (tgt > cur.pos_max)
						tgt = cur.pos_max;
					nxt.pos_target = tgt;
					if (tgt != cur.pos_count) begin
						nxt.direction   = (tgt > cur.pos_count) ? vmpc_pkg::MOVE_OPEN
							: vmpc_pkg::MOVE_CLOSE;
						nxt.drive_pins  = (tgt > cur.pos_count) ? vmpc_pkg::PINS_OPEN
							: vmpc_pkg::PINS_CLOSE;
						nxt.run_ticks   = 16'd0;
						nxt.stall_count = 8'd0;
						nxt.pending_cmd = vmpc_pkg::CMD_SET;
					end else begin
						done = 1'b1;
					end
				end
			end
			vmpc_pkg::OP_AOPEN: begin
				if (!busy) begin
					nxt.direction   = vmpc_pkg::MOVE_OPEN;
					nxt.drive_pins  = vmpc_pkg::PINS_OPEN;
					nxt.run_ticks   = 16'd0;
					nxt.stall_count = 8'd0;
					nxt.pending_cmd = vmpc_pkg::CMD_AOPEN;
				end
			end
			vmpc_pkg::OP_ACLOSE: begin
				if (!busy) begin
					nxt.direction   = vmpc_pkg::MOVE_CLOSE;
					nxt.drive_pins  = vmpc_pkg::PINS_CLOSE;
					nxt.run_ticks   = 16'd0;
					nxt.stall_count = 8'd0;
					nxt.pending_cmd = vmpc_pkg::CMD_ACLOSE;
				end
			end
			default: ;
		endcase

		res.position    = nxt.pos_count;
		res.running     = (nxt.direction != vmpc_pkg::MOVE_OFF);
		res.drive_open  = nxt.drive_pins[0];
		res.drive_close = nxt.drive_pins[1];
		res.adapted     = (nxt.pos_max != 16'sd0);
		res.done_res    = done;
		res.ok          = ok;
	end

endmodule

// ===== src/valve_motor_position_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valve_motor_position_control: encoder valve motor controller
// Takes tick, pulse and command events and reports motor status per event.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake           | payload
//   in       | input     | in_valid / in_stall | in_item (op, target)
//   out      | output    | out_valid/out_stall | out_result (status)
//   config   | input     | APB psel/penable    | pwdata, prdata
//
// One transaction per cycle while the result is not stalled; the result
// register loads when go moves the accepted transaction out of stage 1.
// Stage 1 registers the event, the state update and the result register load
// happen together when go is set. A stalled result holds stage 1, which in
// turn raises in_stall. Reset clears the state and loads register defaults.
// ----------------------------------------------------------------------------
module valve_motor_position_control (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  vmpc_pkg::in_item_t            in_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output vmpc_pkg::out_item_t           out_result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [vmpc_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	vmpc_pkg::cfg_t        cfg;
	vmpc_pkg::in_item_t    item_s1;
	logic                  vld_s1;
	vmpc_pkg::out_item_t   res_s2;
	logic                  vld_s2;
	vmpc_pkg::ctl_state_t  state_q;
	vmpc_pkg::ctl_state_t  state_nxt;
	vmpc_pkg::out_item_t   res_nxt;
	logic                  go;

	vmpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vmpc_core u_core (
		.item (item_s1),
		.cur  (state_q),
		.cfg  (cfg),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// advance stage 1 when the result register is free or being drained
	assign go         = vld_s1 && (!vld_s2 || !out_stall);
	assign in_stall   = vld_s1 && !go;
	assign out_valid  = vld_s2;
	assign out_result = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			state_q.direction   <= vmpc_pkg::MOVE_OFF;
			state_q.drive_pins  <= vmpc_pkg::PINS_OFF;
			state_q.stall_count <= 8'd0;
			state_q.run_ticks   <= 16'd0;
			state_q.pos_count   <= 16'sd0;
			state_q.pos_max     <= 16'sd0;
			state_q.pos_target  <= 16'sd0;
			state_q.pending_cmd <= vmpc_pkg::CMD_NONE;
		end else begin
			if (in_valid && !in_stall)
				vld_s1 <= 1'b1;
			else if (go)
				vld_s1 <= 1'b0;
			if (go)
				vld_s2 <= 1'b1;
			else if (!out_stall)
				vld_s2 <= 1'b0;
			if (go)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_item;
		if (go)
			res_s2 <= res_nxt;
	end

`ifndef SYNTHESIS
	a_pins_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q.drive_pins[0] && state_q.drive_pins[1]))
		else $error("both drive pins active");

	a_idle_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_result.running |-> !out_result.drive_open && !out_result.drive_close)
		else $error("drive active while motor disabled");

	a_ok_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_result.ok |-> out_result.done_res)
		else $error("ok reported without a finished run");

	a_pending_when_running: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.direction != vmpc_pkg::MOVE_OFF |-> state_q.pending_cmd != vmpc_pkg::CMD_NONE)
		else $error("motor running with no pending command");
`endif

endmodule

// ===== test/tb_valve_motor_position_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_valve_motor_position_control: event-level check of the valve controller
// Sends tick, pulse and command events and compares each status transaction
// against an in-bench motor model or a typed row's fixed status. A directed
// table comes first, then random motor runs under three idle mixes and four
// register settings. A long output hold-off backs up the pipeline. A run
// under the longest stall timeout saturates the stall counter.
// ----------------------------------------------------------------------------
module tb_valve_motor_position_control;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 80;

	// Event codes the block must ignore
	localparam logic [2:0] OP_BAD5 = 3'd5;
	localparam logic [2:0] OP_BAD6 = 3'd6;
	localparam logic [2:0] OP_BAD7 = 3'd7;

	// Status words: position, running, open, close, adapted, done, ok
	localparam vmpc_pkg::out_item_t ST_IDLE    = {16'd0, 6'b000000};
	localparam vmpc_pkg::out_item_t ST_DONE    = {16'd0, 6'b000010};
	localparam vmpc_pkg::out_item_t ST_OPENING = {16'd0, 6'b110000};
	localparam vmpc_pkg::out_item_t ST_CLOSING = {16'd0, 6'b101000};

	typedef struct {
		logic [2:0]          op;
		logic [15:0]         tgt;
		int                  reps;
		bit                  typed;
		vmpc_pkg::out_item_t want;
	} vec_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	vmpc_pkg::in_item_t            in_item = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	vmpc_pkg::out_item_t           out_result;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [vmpc_pkg::PADDR_W-1:0]  paddr = '0;
	logic [31:0]                   pwdata = '0;
	logic [31:0]                   prdata;
	logic                          pready;

	valve_motor_position_control u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_result (out_result),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Motor model state and its copy of the registers
	vmpc_pkg::dir_t     dir_q = vmpc_pkg::MOVE_OFF;
	logic [1:0]         pins_q = vmpc_pkg::PINS_OFF;
	logic [7:0]         stall_q = '0;
	logic [15:0]        runt_q = '0;
	logic signed [15:0] pos_q = '0;
	logic signed [15:0] max_q = '0;
	logic signed [15:0] tgt_q = '0;
	vmpc_pkg::cmd_t     cmd_q = vmpc_pkg::CMD_NONE;
	logic [7:0]         cfg_timeout = vmpc_pkg::RST_STALL_TIMEOUT;
	logic [15:0]        cfg_rt_open = vmpc_pkg::RST_MAX_RT_OPEN;
	logic [15:0]        cfg_rt_close = vmpc_pkg::RST_MAX_RT_CLOSE;
	logic [14:0]        cfg_min_range = vmpc_pkg::RST_MIN_RANGE;

	vmpc_pkg::out_item_t expected_status[$];
	vec_t                directed_rows[$];
	int                  errors = 0;
	int                  items_sent = 0;
	int                  status_seen = 0;
	int                  runs_done = 0;
	int                  adapt_ok = 0;
	int                  cycle_cnt = 0;
	int                  snd_idle = 0;
	int                  rcv_idle = 0;
	bit                  hold_req = 1'b0;

	function automatic logic signed [15:0] sat_pos(input int v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic void start_motor(input vmpc_pkg::dir_t d, input vmpc_pkg::cmd_t c);
		dir_q = d;
		pins_q = (d == vmpc_pkg::MOVE_OPEN) ? vmpc_pkg::PINS_OPEN : vmpc_pkg::PINS_CLOSE;
		runt_q = '0;
		stall_q = '0;
		cmd_q = c;
	endfunction

	function automatic vmpc_pkg::out_item_t motor_status(input logic [2:0] op,
		input logic [15:0] tgt_raw);
		vmpc_pkg::out_item_t r;
		int                  tgt;
		bit                  busy;
		r = '0;
		busy = (dir_q != vmpc_pkg::MOVE_OFF);
		case (op)
			vmpc_pkg::OP_TICK: begin
				if (stall_q != 8'hFF) stall_q = stall_q + 8'd1;
				if (stall_q > cfg_timeout) begin
					pins_q = vmpc_pkg::PINS_OFF;
					dir_q = vmpc_pkg::MOVE_OFF;
				end
				if (dir_q != vmpc_pkg::MOVE_OFF && runt_q != 16'hFFFF) runt_q = runt_q + 16'd1;
				if (max_q != 0) begin
					if (dir_q == vmpc_pkg::MOVE_OPEN && int'(pos_q) >= int'(tgt_q))
						pins_q = vmpc_pkg::PINS_OFF;
					else if (dir_q == vmpc_pkg::MOVE_CLOSE && int'(pos_q) <= int'(tgt_q))
						pins_q = vmpc_pkg::PINS_OFF;
				end
				if (cmd_q == vmpc_pkg::CMD_AOPEN && runt_q > cfg_rt_open)
					pins_q = vmpc_pkg::PINS_OFF;
				if (cmd_q == vmpc_pkg::CMD_ACLOSE && runt_q > cfg_rt_close)
					pins_q = vmpc_pkg::PINS_OFF;
				// Run is over once the motor is disabled with a command pending
				if (cmd_q != vmpc_pkg::CMD_NONE && dir_q == vmpc_pkg::MOVE_OFF) begin
					r.done_res = 1'b1;
					if (cmd_q == vmpc_pkg::CMD_AOPEN) begin
						pos_q = '0;
						r.ok = (runt_q <= cfg_rt_open);
					end else if (cmd_q == vmpc_pkg::CMD_ACLOSE && runt_q <= cfg_rt_close) begin
						max_q = sat_pos(-int'(pos_q));
						pos_q = '0;
						if (int'(max_q) < int'(cfg_min_range)) begin
							max_q = '0;
						end else begin
							r.ok = 1'b1;
						end
					end
					cmd_q = vmpc_pkg::CMD_NONE;
				end
			end
			vmpc_pkg::OP_PULSE: begin
				if (dir_q == vmpc_pkg::MOVE_OPEN) pos_q = sat_pos(int'(pos_q) + 1);
				else if (dir_q == vmpc_pkg::MOVE_CLOSE) pos_q = sat_pos(int'(pos_q) - 1);
				stall_q = '0;
			end
			vmpc_pkg::OP_SETPOS: begin
				if (!busy) begin
					tgt = int'($signed(tgt_raw));
					if (tgt < 0) tgt = 0;
					if (tgt > int'(max_q)) tgt = int'(max_q);
					tgt_q = tgt[15:0];
					if (tgt > int'(pos_q)) start_motor(vmpc_pkg::MOVE_OPEN, vmpc_pkg::CMD_SET);
					else if (tgt < int'(pos_q))
						start_motor(vmpc_pkg::MOVE_CLOSE, vmpc_pkg::CMD_SET);
					else r.done_res = 1'b1;
				end
			end
			vmpc_pkg::OP_AOPEN: begin
				if (!busy) start_motor(vmpc_pkg::MOVE_OPEN, vmpc_pkg::CMD_AOPEN);
			end
			vmpc_pkg::OP_ACLOSE: begin
				if (!busy) start_motor(vmpc_pkg::MOVE_CLOSE, vmpc_pkg::CMD_ACLOSE);
			end
			default: begin
			end
		endcase
		r.position = pos_q;
		r.running = (dir_q != vmpc_pkg::MOVE_OFF);
		r.drive_open = pins_q[0];
		r.drive_close = pins_q[1];
		r.adapted = (max_q != 0);
		return r;
	endfunction

	function automatic void field_check(input string name, input logic [15:0] e,
		input logic [15:0] a);
		if (a !== e) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name,
				$signed(e), $signed(a));
			errors++;
		end
	endfunction

	function automatic void check_status(input vmpc_pkg::out_item_t e,
		input vmpc_pkg::out_item_t a);
		field_check("position", e.position, a.position);
		field_check("running", 16'(e.running), 16'(a.running));
		field_check("drive_open", 16'(e.drive_open), 16'(a.drive_open));
		field_check("drive_close", 16'(e.drive_close), 16'(a.drive_close));
		field_check("adapted", 16'(e.adapted), 16'(a.adapted));
		field_check("done_res", 16'(e.done_res), 16'(a.done_res));
		field_check("ok", 16'(e.ok), 16'(a.ok));
	endfunction

	// Result side: check each accepted transaction, then pick the next stall
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				status_seen++;
				if (expected_status.size() == 0) begin
					$display("%0t ns: status transaction with none expected, got %h", $time,
						out_result);
					errors++;
				end else begin
					check_status(expected_status.pop_front(), out_result);
				end
				if (out_result.done_res) runs_done++;
				if (out_result.done_res && out_result.ok) adapt_ok++;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < rcv_idle);
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("%0t ns: cycle limit reached with %0d status transactions outstanding",
			$time, expected_status.size());
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_event(input logic [2:0] op, input logic [15:0] tgt, input bit typed,
		input vmpc_pkg::out_item_t want);
		vmpc_pkg::out_item_t pred;
		int                  gap;
		gap = 0;
		if ($urandom_range(0, 99) < snd_idle) gap = $urandom_range(1, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= {op, tgt};
		do @(posedge clk); while (in_stall);
		pred = motor_status(op, tgt);
		expected_status.push_back(typed ? want : pred);
		items_sent++;
	endtask

	task automatic send_burst(input logic [2:0] op, input logic [15:0] tgt, input int n);
		repeat (n) send_event(op, tgt, 1'b0, '0);
	endtask

	// Drop valid and let every outstanding status transaction come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] val,
		output logic [31:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val,
		input logic [31:0] mask);
		logic [31:0] rd;
		apb_access(1'b1, idx, val, rd);
		apb_access(1'b0, idx, 32'd0, rd);
		if ((rd & mask) !== (val & mask)) begin
			$display("%0t ns: register %0d readback, expected %h, got %h", $time, idx,
				val & mask, rd & mask);
			errors++;
		end
	endtask

	task automatic set_config(input logic [7:0] t, input logic [15:0] ro, input logic [15:0] rc,
		input logic [14:0] mr);
		wait_idle();
		write_reg(vmpc_pkg::REG_STALL_TIMEOUT, {24'd0, t}, 32'h0000_00FF);
		write_reg(vmpc_pkg::REG_MAX_RT_OPEN, {16'd0, ro}, 32'h0000_FFFF);
		write_reg(vmpc_pkg::REG_MAX_RT_CLOSE, {16'd0, rc}, 32'h0000_FFFF);
		write_reg(vmpc_pkg::REG_MIN_RANGE, {17'd0, mr}, 32'h0000_7FFF);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cfg_timeout = t;
		cfg_rt_open = ro;
		cfg_rt_close = rc;
		cfg_min_range = mr;
	endtask

	// Tick until the motor is disabled so the next phase starts from rest
	task automatic settle_motor();
		while (dir_q != vmpc_pkg::MOVE_OFF)
			send_event(vmpc_pkg::OP_TICK, 16'($urandom), 1'b0, '0);
	endtask

	// Mostly command, pulse/tick body, stall-out ticks; some noise and cut-off runs
	task automatic random_runs(input int count);
		int          first;
		int          len;
		int          pct;
		int          k;
		logic [2:0]  cmd;
		logic [15:0] tgt;
		first = items_sent;
		while (items_sent - first < count) begin
			if ($urandom_range(0, 99) < 12) begin
				send_event(3'($urandom_range(0, 7)), 16'($urandom), 1'b0, '0);
			end else begin
				case ($urandom_range(0, 2))
					0: cmd = vmpc_pkg::OP_SETPOS;
					1: cmd = vmpc_pkg::OP_AOPEN;
					default: cmd = vmpc_pkg::OP_ACLOSE;
				endcase
				if ($urandom_range(0, 1)) tgt = 16'($urandom);
				else tgt = 16'($urandom_range(0, int'(max_q) + 20));
				send_event(cmd, tgt, 1'b0, '0);
				len = $urandom_range(0, 160);
				pct = $urandom_range(40, 97);
				for (k = 0; k < len; k++) begin
					send_event(($urandom_range(0, 99) < pct) ? vmpc_pkg::OP_PULSE
						: vmpc_pkg::OP_TICK, 16'($urandom), 1'b0, '0);
				end
				if ($urandom_range(0, 4) != 0)
					send_burst(vmpc_pkg::OP_TICK, 16'($urandom),
						int'(cfg_timeout) + $urandom_range(1, 3));
			end
		end
	endtask

	function automatic void add_row(input logic [2:0] op, input logic [15:0] tgt, input int reps,
		input bit typed, input vmpc_pkg::out_item_t want);
		vec_t v;
		v.op = op;
		v.tgt = tgt;
		v.reps = reps;
		v.typed = typed;
		v.want = want;
		directed_rows.push_back(v);
	endfunction

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under reset register values
		snd_idle = 35;
		rcv_idle = 55;
		add_row(vmpc_pkg::OP_TICK, 16'h0000, 1, 1'b1, ST_IDLE);
		add_row(vmpc_pkg::OP_PULSE, 16'hFFFF, 1, 1'b1, ST_IDLE);
		add_row(vmpc_pkg::OP_SETPOS, 16'h7FFF, 1, 1'b1, ST_DONE);
		add_row(vmpc_pkg::OP_SETPOS, 16'h8000, 1, 1'b1, ST_DONE);
		add_row(OP_BAD5, 16'hFFFF, 1, 1'b1, ST_IDLE);
		add_row(OP_BAD7, 16'h5A5A, 1, 1'b1, ST_IDLE);
		add_row(vmpc_pkg::OP_AOPEN, 16'h0000, 1, 1'b1, ST_OPENING);
		add_row(vmpc_pkg::OP_SETPOS, 16'd100, 1, 1'b1, ST_OPENING);
		add_row(vmpc_pkg::OP_ACLOSE, 16'h0000, 1, 1'b1, ST_OPENING);
		add_row(vmpc_pkg::OP_PULSE, 16'h0000, 3, 1'b0, '0);
		add_row(vmpc_pkg::OP_TICK, 16'h0000, 25, 1'b0, '0);
		add_row(vmpc_pkg::OP_ACLOSE, 16'h0000, 1, 1'b1, ST_CLOSING);
		add_row(vmpc_pkg::OP_PULSE, 16'h0000, 150, 1'b0, '0);
		add_row(vmpc_pkg::OP_TICK, 16'h0000, 22, 1'b0, '0);
		add_row(vmpc_pkg::OP_SETPOS, 16'd50, 1, 1'b0, '0);
		add_row(vmpc_pkg::OP_PULSE, 16'h0000, 60, 1'b0, '0);
		add_row(vmpc_pkg::OP_TICK, 16'h0000, 22, 1'b0, '0);
		add_row(vmpc_pkg::OP_SETPOS, 16'h7FFF, 1, 1'b0, '0);
		add_row(vmpc_pkg::OP_PULSE, 16'h0000, 60, 1'b0, '0);
		add_row(vmpc_pkg::OP_TICK, 16'h0000, 22, 1'b0, '0);
		add_row(vmpc_pkg::OP_SETPOS, 16'h8000, 1, 1'b0, '0);
		add_row(vmpc_pkg::OP_PULSE, 16'h0000, 120, 1'b0, '0);
		add_row(vmpc_pkg::OP_TICK, 16'h0000, 22, 1'b0, '0);
		add_row(vmpc_pkg::OP_ACLOSE, 16'h0000, 1, 1'b0, '0);
		add_row(vmpc_pkg::OP_PULSE, 16'h0000, 10, 1'b0, '0);
		add_row(vmpc_pkg::OP_TICK, 16'h0000, 22, 1'b0, '0);
		add_row(OP_BAD6, 16'h8001, 1, 1'b0, '0);
		foreach (directed_rows[i]) begin
			if (directed_rows[i].typed)
				send_event(directed_rows[i].op, directed_rows[i].tgt, 1'b1, directed_rows[i].want);
			else
				send_burst(directed_rows[i].op, directed_rows[i].tgt, directed_rows[i].reps);
		end
		random_runs(60);
		settle_motor();

		// Shortest stall timeout, zero open limit, widest close limit
		snd_idle = 55;
		rcv_idle = 35;
		set_config(8'd1, 16'd0, 16'hFFFF, 15'd0);
		random_runs(60);
		settle_motor();

		// Mid settings, no idling, with one long output hold-off
		snd_idle = 0;
		rcv_idle = 0;
		set_config(8'd10, 16'd300, 16'd300, 15'd50);
		hold_req = 1'b1;
		random_runs(60);
		settle_motor();

		// Saturate the stall counter; the motor never stalls out at 255
		set_config(8'd255, 16'hFFFF, 16'hFFFF, 15'h7FFF);
		send_event(vmpc_pkg::OP_AOPEN, 16'h0000, 1'b0, '0);
		send_burst(vmpc_pkg::OP_PULSE, 16'h0000, 20);
		send_burst(vmpc_pkg::OP_TICK, 16'h0000, 270);
		set_config(8'd3, 16'hFFFF, 16'hFFFF, 15'h7FFF);
		send_burst(vmpc_pkg::OP_TICK, 16'h0000, 5);
		send_event(vmpc_pkg::OP_ACLOSE, 16'h0000, 1'b0, '0);
		send_burst(vmpc_pkg::OP_PULSE, 16'h0000, 30);
		send_burst(vmpc_pkg::OP_TICK, 16'h0000, 5);
		send_event(vmpc_pkg::OP_SETPOS, 16'h7FFF, 1'b0, '0);
		send_burst(vmpc_pkg::OP_PULSE, 16'h0000, 10);
		send_burst(vmpc_pkg::OP_TICK, 16'h0000, 5);

		// Zero runtime limits: both adapt runs overrun
		set_config(8'd3, 16'd0, 16'd0, 15'd0);
		send_event(vmpc_pkg::OP_AOPEN, 16'h0000, 1'b0, '0);
		send_burst(vmpc_pkg::OP_PULSE, 16'h0000, 2);
		send_burst(vmpc_pkg::OP_TICK, 16'h0000, 5);
		send_event(vmpc_pkg::OP_ACLOSE, 16'h0000, 1'b0, '0);
		send_burst(vmpc_pkg::OP_PULSE, 16'h0000, 2);
		send_burst(vmpc_pkg::OP_TICK, 16'h0000, 5);
		random_runs(20);
		wait_idle();

		$display("Sent %0d events, checked %0d status transactions, %0d runs ended, %0d ok.",
			items_sent, status_seen, runs_done, adapt_ok);
		$display("Six register settings, three idle mixes, a long hold-off, stall saturation.");
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== valve_motor_position_control.f =====
src/vmpc_pkg.sv
src/vmpc_regs.sv
src/vmpc_core.sv
src/valve_motor_position_control.sv
test/tb_valve_motor_position_control.sv
